### rtl/refcounted_handle_cache_defines.svh
// ----------------------------------------------------------------------------
// Refcounted handle cache assertion macros
// Shared property forms for the cache's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_HANDLE_CACHE_DEFINES_SVH
`define REFCOUNTED_HANDLE_CACHE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define RHC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// Refcounted handle cache package
// Sizes, request codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

   localparam int ENTRIES     = 8;
   localparam int IDX_BITS    = $clog2(ENTRIES);
   localparam int KEY_BITS    = 64;
   localparam int HANDLE_BITS = 16;
   localparam int REF_BITS    = 16;

   localparam logic FUNC_GET     = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   typedef struct packed {
      logic load;    // capture request, restart scan
      logic step;    // examine one entry
      logic finish;  // update entry, load response register
   } rhc_cmd_type;

   typedef struct packed {
      logic scan_done;  // match found or last entry examined
   } rhc_sts_type;

endpackage

`default_nettype wire

### rtl/rhc_datapath.sv
// ----------------------------------------------------------------------------
// Refcounted handle cache datapath
// Entry table, one-entry-per-cycle scan trackers, update decision and
// response payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire rhc_pkg::rhc_cmd_type             cmd,
   output rhc_pkg::rhc_sts_type                  sts,
   input  wire logic                             req_func,
   input  wire logic [rhc_pkg::KEY_BITS-1:0]     req_key,
   input  wire logic [rhc_pkg::HANDLE_BITS-1:0]  req_handle,
   input  wire logic                             req_drop_at_zero,
   output logic                                  rsp_hit,
   output logic [rhc_pkg::HANDLE_BITS-1:0]       rsp_result_handle,
   output logic                                  rsp_inserted,
   output logic                                  rsp_cache_full,
   output logic [rhc_pkg::HANDLE_BITS-1:0]       rsp_free_handle,
   output logic [rhc_pkg::IDX_BITS-1:0]          rsp_slot,
   output logic [rhc_pkg::REF_BITS-1:0]          rsp_ref_after
);

   localparam logic [rhc_pkg::IDX_BITS-1:0] LAST_IDX = rhc_pkg::IDX_BITS'(rhc_pkg::ENTRIES - 1);

   // entry table; a zero handle marks an empty entry
   logic [rhc_pkg::KEY_BITS-1:0]    ent_key_ff  [rhc_pkg::ENTRIES];
   logic [rhc_pkg::HANDLE_BITS-1:0] ent_hdl_ff  [rhc_pkg::ENTRIES];
   logic [rhc_pkg::REF_BITS-1:0]    ent_refs_ff [rhc_pkg::ENTRIES];

   // captured request
   logic                            rq_func_ff;
   logic [rhc_pkg::KEY_BITS-1:0]    rq_key_ff;
   logic [rhc_pkg::HANDLE_BITS-1:0] rq_hdl_ff;
   logic                            rq_dk_ff;

   // scan trackers
   logic [rhc_pkg::IDX_BITS-1:0]    idx_ff;
   logic                            found_ff;
   logic [rhc_pkg::IDX_BITS-1:0]    found_idx_ff;
   logic [rhc_pkg::HANDLE_BITS-1:0] found_hdl_ff;
   logic [rhc_pkg::REF_BITS-1:0]    found_refs_ff;
   logic                            empty_ok_ff;
   logic [rhc_pkg::IDX_BITS-1:0]    empty_idx_ff;
   logic                            unref_ok_ff;
   logic [rhc_pkg::IDX_BITS-1:0]    unref_idx_ff;
   logic [rhc_pkg::HANDLE_BITS-1:0] unref_hdl_ff;

   // current entry
   logic [rhc_pkg::KEY_BITS-1:0]    cur_key;
   logic [rhc_pkg::HANDLE_BITS-1:0] cur_hdl;
   logic [rhc_pkg::REF_BITS-1:0]    cur_refs;
   logic                            cur_empty;
   logic                            match;
   logic                            rec_empty;
   logic                            rec_unref;

   // update decision
   logic [rhc_pkg::REF_BITS-1:0]    inc_refs;
   logic [rhc_pkg::REF_BITS-1:0]    dec_refs;
   logic                            wr_en;
   logic                            wr_key_en;
   logic [rhc_pkg::IDX_BITS-1:0]    wr_idx;
   logic [rhc_pkg::HANDLE_BITS-1:0] wr_hdl;
   logic [rhc_pkg::REF_BITS-1:0]    wr_refs;
   logic                            o_hit;
   logic [rhc_pkg::HANDLE_BITS-1:0] o_res;
   logic                            o_ins;
   logic                            o_full;
   logic [rhc_pkg::HANDLE_BITS-1:0] o_free;
   logic [rhc_pkg::IDX_BITS-1:0]    o_slot;
   logic [rhc_pkg::REF_BITS-1:0]    o_refs;

   logic                            rsp_hit_ff;
   logic [rhc_pkg::HANDLE_BITS-1:0] rsp_res_ff;
   logic                            rsp_ins_ff;
   logic                            rsp_full_ff;
   logic [rhc_pkg::HANDLE_BITS-1:0] rsp_free_ff;
   logic [rhc_pkg::IDX_BITS-1:0]    rsp_slot_ff;
   logic [rhc_pkg::REF_BITS-1:0]    rsp_refs_ff;

   always_comb begin
      cur_key   = ent_key_ff[idx_ff];
      cur_hdl   = ent_hdl_ff[idx_ff];
      cur_refs  = ent_refs_ff[idx_ff];
      cur_empty = (cur_hdl == '0);
      match     = ((rq_func_ff == rhc_pkg::FUNC_GET) && !cur_empty && (cur_key == rq_key_ff))
               || ((rq_func_ff == rhc_pkg::FUNC_RELEASE) && (rq_hdl_ff != '0)
                   && (cur_hdl == rq_hdl_ff));
      rec_empty = !match && cur_empty && !empty_ok_ff;
      rec_unref = !match && !cur_empty && (cur_refs == '0) && !unref_ok_ff;
      sts.scan_done = match || (idx_ff == LAST_IDX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         found_ff    <= 1'b0;
         empty_ok_ff <= 1'b0;
         unref_ok_ff <= 1'b0;
      end else if (cmd.load) begin
         idx_ff      <= '0;
         found_ff    <= 1'b0;
         empty_ok_ff <= 1'b0;
         unref_ok_ff <= 1'b0;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + 1'b1;
         if (match) found_ff <= 1'b1;
         if (rec_empty) empty_ok_ff <= 1'b1;
         if (rec_unref) unref_ok_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rq_func_ff <= req_func;
         rq_key_ff  <= req_key;
         rq_hdl_ff  <= req_handle;
         rq_dk_ff   <= req_drop_at_zero;
      end
      if (cmd.step && match) begin
         found_idx_ff  <= idx_ff;
         found_hdl_ff  <= cur_hdl;
         found_refs_ff <= cur_refs;
      end
      if (cmd.step && rec_empty) empty_idx_ff <= idx_ff;
      if (cmd.step && rec_unref) begin
         unref_idx_ff <= idx_ff;
         unref_hdl_ff <= cur_hdl;
      end
   end

   always_comb begin
      inc_refs  = (found_refs_ff == '1) ? found_refs_ff : found_refs_ff + 1'b1;
      dec_refs  = (found_refs_ff == '0) ? '0 : found_refs_ff - 1'b1;
      wr_en     = 1'b0;
      wr_key_en = 1'b0;
      wr_idx    = found_idx_ff;
      wr_hdl    = found_hdl_ff;
      wr_refs   = found_refs_ff;
      o_hit     = 1'b0;
      o_res     = '0;
      o_ins     = 1'b0;
      o_full    = 1'b0;
      o_free    = '0;
      o_slot    = '0;
      o_refs    = '0;
      if (rq_func_ff == rhc_pkg::FUNC_GET) begin
         if (found_ff) begin
            wr_en   = 1'b1;
            wr_refs = inc_refs;
            o_hit   = 1'b1;
            o_res   = found_hdl_ff;
            o_slot  = found_idx_ff;
            o_refs  = inc_refs;
         end else if (rq_hdl_ff != '0) begin
            o_res = rq_hdl_ff;
            if (empty_ok_ff || unref_ok_ff) begin
               wr_en     = 1'b1;
               wr_key_en = 1'b1;
               wr_idx    = empty_ok_ff ? empty_idx_ff : unref_idx_ff;
               wr_hdl    = rq_hdl_ff;
               wr_refs   = rhc_pkg::REF_BITS'(1);
               o_ins     = 1'b1;
               o_free    = empty_ok_ff ? '0 : unref_hdl_ff;
               o_slot    = wr_idx;
               o_refs    = rhc_pkg::REF_BITS'(1);
            end else begin
               o_full = 1'b1;
            end
         end
      end else if (found_ff) begin
         wr_en  = 1'b1;
         o_hit  = 1'b1;
         o_slot = found_idx_ff;
         if ((dec_refs == '0) && rq_dk_ff) begin
            // last reference gone: drop the entry, caller frees the handle
            wr_hdl  = '0;
            wr_refs = '0;
            o_free  = rq_hdl_ff;
         end else begin
            wr_refs = dec_refs;
            o_refs  = dec_refs;
         end
      end else begin
         o_free = rq_hdl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rhc_pkg::ENTRIES; i++) begin
            ent_hdl_ff[i]  <= '0;
            ent_refs_ff[i] <= '0;
         end
      end else if (cmd.finish && wr_en) begin
         ent_hdl_ff[wr_idx]  <= wr_hdl;
         ent_refs_ff[wr_idx] <= wr_refs;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && wr_en && wr_key_en) ent_key_ff[wr_idx] <= rq_key_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_hit_ff  <= o_hit;
         rsp_res_ff  <= o_res;
         rsp_ins_ff  <= o_ins;
         rsp_full_ff <= o_full;
         rsp_free_ff <= o_free;
         rsp_slot_ff <= o_slot;
         rsp_refs_ff <= o_refs;
      end
   end

   assign rsp_hit           = rsp_hit_ff;
   assign rsp_result_handle = rsp_res_ff;
   assign rsp_inserted      = rsp_ins_ff;
   assign rsp_cache_full    = rsp_full_ff;
   assign rsp_free_handle   = rsp_free_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_ref_after     = rsp_refs_ff;

endmodule

`default_nettype wire

### rtl/rhc_ctrl.sv
// ----------------------------------------------------------------------------
// Refcounted handle cache controller
// Sequences accept, scan and update, and owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "refcounted_handle_cache_defines.svh"

module rhc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rhc_pkg::rhc_cmd_type       cmd,
   input  wire rhc_pkg::rhc_sts_type  sts
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      cmd.load   = req_valid && !req_stall;
      cmd.step   = (state_ff == ST_SCAN);
      cmd.finish = (state_ff == ST_FINISH) && out_free;

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (cmd.load) state_in = ST_SCAN;
         ST_SCAN:   if (sts.scan_done) state_in = ST_FINISH;
         ST_FINISH: if (cmd.finish) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase

      // result register: refilled on finish, emptied when the beat is taken
      if (cmd.finish) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `RHC_ASSERT_NEXT(a_load_starts_scan, clock, reset, cmd.load, state_ff == ST_SCAN, "accept did not start scan")
   `RHC_ASSERT_NEXT(a_finish_fills_rsp, clock, reset, cmd.finish, rsp_valid_ff && (state_ff == ST_IDLE), "finish did not present result")
   `RHC_ASSERT_NEXT(a_pending_holds, clock, reset, (state_ff == ST_FINISH) && rsp_valid_ff && rsp_stall, state_ff == ST_FINISH, "result overwritten while stalled")
   `RHC_ASSERT_SAME(a_no_accept_busy, clock, reset, cmd.load, state_ff == ST_IDLE, "accept outside idle")

endmodule

`default_nettype wire

### rtl/refcounted_handle_cache.sv
// ----------------------------------------------------------------------------
// Refcounted handle cache
// Eight-entry fully associative cache of reference-counted object handles.
// ----------------------------------------------------------------------------
// One request is handled at a time. After the accepting edge the table is
// scanned one entry per cycle, stopping at the first match, then an update
// step writes the entry and loads the result register; that step waits while
// a pending result is stalled. A new request may be accepted as soon as the
// update is done, while the previous result still waits in its output
// register. All entries are empty after reset; no clearing pass is needed.
`default_nettype none

module refcounted_handle_cache (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_func,
   input  wire logic [rhc_pkg::KEY_BITS-1:0]     req_key,
   input  wire logic [rhc_pkg::HANDLE_BITS-1:0]  req_handle,
   input  wire logic                             req_drop_at_zero,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_hit,
   output logic [rhc_pkg::HANDLE_BITS-1:0]       rsp_result_handle,
   output logic                                  rsp_inserted,
   output logic                                  rsp_cache_full,
   output logic [rhc_pkg::HANDLE_BITS-1:0]       rsp_free_handle,
   output logic [rhc_pkg::IDX_BITS-1:0]          rsp_slot,
   output logic [rhc_pkg::REF_BITS-1:0]          rsp_ref_after
);

   rhc_pkg::rhc_cmd_type cmd;
   rhc_pkg::rhc_sts_type sts;

   rhc_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_key           (req_key),
      .req_handle        (req_handle),
      .req_drop_at_zero  (req_drop_at_zero),
      .rsp_hit           (rsp_hit),
      .rsp_result_handle (rsp_result_handle),
      .rsp_inserted      (rsp_inserted),
      .rsp_cache_full    (rsp_cache_full),
      .rsp_free_handle   (rsp_free_handle),
      .rsp_slot          (rsp_slot),
      .rsp_ref_after     (rsp_ref_after)
   );

   rhc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

### sim/handle_cache_checker.sv
// ----------------------------------------------------------------------------
// Refcounted handle cache checker
// Watches the request and reply channels, keeps its own copy of the handle
// table, predicts each reply and compares the replies in order.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_cache_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire logic                             req_func,
   input  wire logic [rhc_pkg::KEY_BITS-1:0]     req_key,
   input  wire logic [rhc_pkg::HANDLE_BITS-1:0]  req_handle,
   input  wire logic                             req_drop_at_zero,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire logic                             rsp_hit,
   input  wire logic [rhc_pkg::HANDLE_BITS-1:0]  rsp_result_handle,
   input  wire logic                             rsp_inserted,
   input  wire logic                             rsp_cache_full,
   input  wire logic [rhc_pkg::HANDLE_BITS-1:0]  rsp_free_handle,
   input  wire logic [rhc_pkg::IDX_BITS-1:0]     rsp_slot,
   input  wire logic [rhc_pkg::REF_BITS-1:0]     rsp_ref_after,
   output int                                    mismatch_count,
   output int                                    results_pending,
   output logic                                  room_for_insert,
   output logic [rhc_pkg::HANDLE_BITS-1:0]       drain_handle,
   output int                                    hit_count,
   output int                                    insert_count,
   output int                                    full_count
);

   typedef struct packed {
      logic                            hit;
      logic [rhc_pkg::HANDLE_BITS-1:0] result_handle;
      logic                            inserted;
      logic                            cache_full;
      logic [rhc_pkg::HANDLE_BITS-1:0] free_handle;
      logic [rhc_pkg::IDX_BITS-1:0]    slot;
      logic [rhc_pkg::REF_BITS-1:0]    ref_after;
   } cache_reply_type;

   logic [rhc_pkg::KEY_BITS-1:0]    tbl_key    [rhc_pkg::ENTRIES];
   logic [rhc_pkg::HANDLE_BITS-1:0] tbl_handle [rhc_pkg::ENTRIES];
   logic [rhc_pkg::REF_BITS-1:0]    tbl_refs   [rhc_pkg::ENTRIES];

   cache_reply_type pending_replies [$];
   int mismatches = 0;

   // Applies one request to the table copy and returns the reply it causes.
   function automatic cache_reply_type predict_lookup(input logic func,
         input logic [rhc_pkg::KEY_BITS-1:0] key,
         input logic [rhc_pkg::HANDLE_BITS-1:0] handle,
         input logic drop_at_zero);
      cache_reply_type r;
      int first_empty;
      int first_unref;
      int victim;
      r = '0;
      first_empty = -1;
      first_unref = -1;
      if (func == rhc_pkg::FUNC_GET) begin
         for (int i = 0; i < rhc_pkg::ENTRIES; i++) begin
            if (tbl_handle[i] == '0) begin
               if (first_empty < 0) first_empty = i;
            end else if (tbl_key[i] == key) begin
               if (tbl_refs[i] != '1) tbl_refs[i] = tbl_refs[i] + 1'b1;
               r.hit = 1'b1;
               r.result_handle = tbl_handle[i];
               r.slot = rhc_pkg::IDX_BITS'(i);
               r.ref_after = tbl_refs[i];
               return r;
            end else if (first_unref < 0 && tbl_refs[i] == '0) begin
               first_unref = i;
            end
         end
         // load failed: nothing cached, nothing reported
         if (handle == '0) return r;
         victim = (first_empty >= 0) ? first_empty : first_unref;
         r.result_handle = handle;
         if (victim < 0) begin
            r.cache_full = 1'b1;
            return r;
         end
         r.inserted = 1'b1;
         r.free_handle = tbl_handle[victim];
         r.slot = rhc_pkg::IDX_BITS'(victim);
         r.ref_after = rhc_pkg::REF_BITS'(1);
         tbl_key[victim] = key;
         tbl_handle[victim] = handle;
         tbl_refs[victim] = rhc_pkg::REF_BITS'(1);
         return r;
      end
      if (handle == '0) return r;
      for (int i = 0; i < rhc_pkg::ENTRIES; i++) begin
         if (tbl_handle[i] == handle) begin
            if (tbl_refs[i] != '0) tbl_refs[i] = tbl_refs[i] - 1'b1;
            r.hit = 1'b1;
            r.slot = rhc_pkg::IDX_BITS'(i);
            if (tbl_refs[i] == '0 && drop_at_zero) begin
               tbl_key[i] = '0;
               tbl_handle[i] = '0;
               r.free_handle = handle;
            end else begin
               r.ref_after = tbl_refs[i];
            end
            return r;
         end
      end
      r.free_handle = handle;
      return r;
   endfunction

   task automatic check_field(input string fname, input logic [63:0] want,
         input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t checker: %s mismatch, expected 0x%0h, actual 0x%0h",
            $time, fname, want, got);
      end
   endtask

   always @(posedge clock) begin
      cache_reply_type want;
      logic room;
      logic [rhc_pkg::HANDLE_BITS-1:0] busy_handle;
      if (reset) begin
         for (int i = 0; i < rhc_pkg::ENTRIES; i++) begin
            tbl_key[i] = '0;
            tbl_handle[i] = '0;
            tbl_refs[i] = '0;
         end
         pending_replies.delete();
         hit_count <= 0;
         insert_count <= 0;
         full_count <= 0;
      end else begin
         // reply side first: a reply never belongs to a request taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               mismatches++;
               $display("%0t checker: unexpected reply beat, expected none, actual hit=%0b slot=%0d",
                  $time, rsp_hit, rsp_slot);
            end else begin
               want = pending_replies.pop_front();
               check_field("hit", 64'(want.hit), 64'(rsp_hit));
               check_field("result_handle", 64'(want.result_handle), 64'(rsp_result_handle));
               check_field("inserted", 64'(want.inserted), 64'(rsp_inserted));
               check_field("cache_full", 64'(want.cache_full), 64'(rsp_cache_full));
               check_field("free_handle", 64'(want.free_handle), 64'(rsp_free_handle));
               check_field("slot", 64'(want.slot), 64'(rsp_slot));
               check_field("ref_after", 64'(want.ref_after), 64'(rsp_ref_after));
               hit_count <= hit_count + int'(want.hit);
               insert_count <= insert_count + int'(want.inserted);
               full_count <= full_count + int'(want.cache_full);
            end
         end
         if (req_valid && !req_stall)
            pending_replies.push_back(predict_lookup(req_func, req_key, req_handle,
               req_drop_at_zero));
      end
      room = 1'b0;
      busy_handle = '0;
      for (int i = 0; i < rhc_pkg::ENTRIES; i++) begin
         if (tbl_handle[i] == '0 || tbl_refs[i] == '0) room = 1'b1;
         else if (busy_handle == '0) busy_handle = tbl_handle[i];
      end
      mismatch_count <= mismatches;
      results_pending <= pending_replies.size();
      room_for_insert <= room;
      drain_handle <= busy_handle;
   end

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Refcounted handle cache testbench
// Drives directed and random get/release traffic with random idling on both
// channels and a long reply hold-off; the checker predicts and compares
// every reply.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int RANDOM_ITEMS = 730;
   localparam int POOL_SIZE = 12;
   localparam int SETTLE_CYCLES = 2 * rhc_pkg::ENTRIES + 4;
   localparam int HOLD_CYCLES = 200;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_func;
   logic [rhc_pkg::KEY_BITS-1:0] req_key;
   logic [rhc_pkg::HANDLE_BITS-1:0] req_handle;
   logic req_drop_at_zero;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_hit;
   logic [rhc_pkg::HANDLE_BITS-1:0] rsp_result_handle;
   logic rsp_inserted;
   logic rsp_cache_full;
   logic [rhc_pkg::HANDLE_BITS-1:0] rsp_free_handle;
   logic [rhc_pkg::IDX_BITS-1:0] rsp_slot;
   logic [rhc_pkg::REF_BITS-1:0] rsp_ref_after;

   int mismatch_count;
   int results_pending;
   logic room_for_insert;
   logic [rhc_pkg::HANDLE_BITS-1:0] drain_handle;
   int hit_count;
   int insert_count;
   int full_count;

   logic [rhc_pkg::KEY_BITS-1:0] key_pool [POOL_SIZE];
   logic [rhc_pkg::HANDLE_BITS-1:0] handle_pool [POOL_SIZE];
   logic quiet;
   logic hold_request;
   int cycle_count = 0;
   int sent_count = 0;

   refcounted_handle_cache DUT (.*);

   handle_cache_checker reply_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Offers one request beat, idling first now and then, and waits until it is taken.
   task automatic send_request(input logic func, input logic [rhc_pkg::KEY_BITS-1:0] key,
         input logic [rhc_pkg::HANDLE_BITS-1:0] handle, input logic drop_at_zero);
      if (!quiet && ((sent_count / 40) % 2 == 0) && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_key <= key;
      req_handle <= handle;
      req_drop_at_zero <= drop_at_zero;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed traffic: each pool key goes with the handle at its pool index so
   // releases find the entries that gets created; the rest is noise.
   task automatic random_request();
      int sel;
      int kind;
      logic [rhc_pkg::KEY_BITS-1:0] rnd_key;
      logic dk;
      sel = $urandom_range(0, POOL_SIZE - 1);
      kind = $urandom_range(0, 99);
      rnd_key = {$urandom, $urandom};
      dk = ($urandom_range(0, 3) == 0);
      if (kind < 48)
         send_request(rhc_pkg::FUNC_GET, key_pool[sel], handle_pool[sel], dk);
      else if (kind < 88)
         send_request(rhc_pkg::FUNC_RELEASE, rnd_key, handle_pool[sel], dk);
      else if (kind < 92)
         send_request(rhc_pkg::FUNC_GET, rnd_key, rhc_pkg::HANDLE_BITS'($urandom), dk);
      else if (kind < 95)
         send_request(rhc_pkg::FUNC_GET, (kind < 94) ? key_pool[sel] : rnd_key, '0, dk);
      else if (kind < 97)
         send_request(rhc_pkg::FUNC_RELEASE, rnd_key, '0, dk);
      else
         send_request(rhc_pkg::FUNC_RELEASE, rnd_key, rhc_pkg::HANDLE_BITS'($urandom), dk);
   endtask

   initial begin : receiver
      logic hold_done;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            // long hold-off: the result register stays full and the cache must stall its input
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && ((cycle_count / 256) % 2 == 0)
               && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int directed_sent;
      int random_sent;
      int drain_sent;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= rhc_pkg::FUNC_GET;
      req_key <= '0;
      req_handle <= '0;
      req_drop_at_zero <= 1'b0;
      quiet <= 1'b0;
      hold_request <= 1'b0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = {$urandom, $urandom};
         handle_pool[i] = rhc_pkg::HANDLE_BITS'($urandom_range(1, 65535));
      end
      key_pool[0] = '0;
      key_pool[1] = '1;
      handle_pool[1] = '1;
      handle_pool[11] = handle_pool[3];   // two keys sharing one handle
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-table corner cases, then fill, evict, drop and overflow
      send_request(rhc_pkg::FUNC_RELEASE, '0, '0, 1'b1);
      send_request(rhc_pkg::FUNC_RELEASE, '0, 16'h1234, 1'b0);
      send_request(rhc_pkg::FUNC_GET, '1, '0, 1'b0);
      send_request(rhc_pkg::FUNC_GET, '1, 16'hFFFF, 1'b0);
      send_request(rhc_pkg::FUNC_GET, '1, 16'h0001, 1'b1);
      send_request(rhc_pkg::FUNC_GET, '0, 16'h0001, 1'b0);
      send_request(rhc_pkg::FUNC_GET, 64'h8000_0000_0000_0001, 16'h8000, 1'b0);
      send_request(rhc_pkg::FUNC_GET, 64'h0123_4567_89AB_CDEF, 16'h0001, 1'b0);
      send_request(rhc_pkg::FUNC_RELEASE, '1, 16'h0001, 1'b0);
      send_request(rhc_pkg::FUNC_RELEASE, '0, 16'h0001, 1'b0);
      for (int i = 0; i < 4; i++)
         send_request(rhc_pkg::FUNC_GET, rhc_pkg::KEY_BITS'(64'h10 + i),
            rhc_pkg::HANDLE_BITS'(16'h10 + i), 1'b0);
      send_request(rhc_pkg::FUNC_GET, 64'h20, 16'h0020, 1'b0);
      send_request(rhc_pkg::FUNC_RELEASE, '0, 16'h0001, 1'b1);
      send_request(rhc_pkg::FUNC_GET, 64'h21, 16'h0021, 1'b0);
      send_request(rhc_pkg::FUNC_GET, 64'h22, 16'h0022, 1'b0);
      send_request(rhc_pkg::FUNC_GET, 64'h22, '0, 1'b0);
      send_request(rhc_pkg::FUNC_RELEASE, '0, 16'hFFFF, 1'b1);
      send_request(rhc_pkg::FUNC_RELEASE, '0, 16'hFFFF, 1'b1);
      send_request(rhc_pkg::FUNC_RELEASE, '0, 16'h8000, 1'b0);
      send_request(rhc_pkg::FUNC_GET, 64'h22, 16'h5555, 1'b0);
      send_request(rhc_pkg::FUNC_GET, 64'h23, 16'hAAAA, 1'b0);
      directed_sent = sent_count;
      pause_until_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) hold_request <= 1'b1;
         if (n == 400) pause_until_drained();
         if (n == RANDOM_ITEMS - 100) quiet <= 1'b1;
         random_request();
      end
      random_sent = sent_count - directed_sent;
      pause_until_drained();

      // release the first busy entry until some entry can take a new key
      while (!room_for_insert) begin
         send_request(rhc_pkg::FUNC_RELEASE, '0, drain_handle, 1'b1);
         pause_until_drained();
      end
      drain_sent = sent_count - directed_sent - random_sent;

      $display("summary: %0d requests: %0d directed, %0d random, %0d drain releases",
         sent_count, directed_sent, random_sent, drain_sent);
      $display("summary: %0d hits, %0d inserts, %0d cache-full misses",
         hit_count, insert_count, full_count);
      if (mismatch_count == 0 && results_pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin : watchdog
      #30000000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl
rtl/rhc_pkg.sv
rtl/rhc_datapath.sv
rtl/rhc_ctrl.sv
rtl/refcounted_handle_cache.sv
sim/handle_cache_checker.sv
sim/testbench.sv
